[hw/rtl/pcbd_pkg.sv]
// ----------------------------------------------------------------------------
// pcbd_pkg
// Field widths, table entry layout and transaction kinds for the prefix
// code bit decoder.
// ----------------------------------------------------------------------------
package pcbd_pkg;

   localparam int SYM_W   = 7;
   localparam int LEN_W   = 4;
   localparam int CODE_W  = 12;
   localparam int ENTRY_W = LEN_W + CODE_W;

   typedef enum logic {
      KIND_LOAD = 1'b0,
      KIND_BIT  = 1'b1
   } kind_type;

   typedef struct packed {
      logic [LEN_W-1:0]  len;
      logic [CODE_W-1:0] code;
   } entry_type;

endpackage

[hw/rtl/pcbd_ram.sv]
// ----------------------------------------------------------------------------
// pcbd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pcbd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/prefix_code_bit_decoder_unit.sv]
// ----------------------------------------------------------------------------
// prefix_code_bit_decoder_unit
// Bit-serial prefix (Huffman) code decoder with a RAM-held code table.
// ----------------------------------------------------------------------------
// A load transaction (req_kind = 0) writes one table entry and never raises
// busy. A bit transaction (req_kind = 1) shifts the bit into the accumulator
// and then scans the code table through its one read port, one entry per
// cycle, lowest index first: busy stays high until the first matching entry
// is found or the whole table has been checked. Any result appears on rsp_*
// for exactly one cycle with rsp_strobe high, in the same cycle that busy
// falls; it is not held, so the receiver must take it then.
// The table reads as empty after reset through per-entry valid flops, so no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module prefix_code_bit_decoder_unit
   import pcbd_pkg::*;
#(
   parameter int NUM_SYMBOLS  = 128,
   parameter int MAX_CODE_LEN = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_kind,
   input  logic              req_code_bit,
   input  logic [SYM_W-1:0]  req_entry_symbol,
   input  logic [LEN_W-1:0]  req_entry_length,
   input  logic [CODE_W-1:0] req_entry_code,
   output logic              rsp_strobe,
   output logic [SYM_W-1:0]  rsp_symbol,
   output logic              rsp_overflow_error
);

   localparam int IDX_W  = $clog2(NUM_SYMBOLS);
   localparam int ACC_W  = MAX_CODE_LEN;
   localparam int ALEN_W = $clog2(MAX_CODE_LEN + 1);
   localparam int CMP_W  = (MAX_CODE_LEN > CODE_W) ? MAX_CODE_LEN : CODE_W;
   localparam int CLEN_W = 6;
   localparam int MASK_W = CODE_W + 1;
   localparam int RNG_W  = 9;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type         state_ff;
   logic [ACC_W-1:0]  accum_bits_ff;
   logic [ALEN_W-1:0] accum_len_ff;
   logic [NUM_SYMBOLS-1:0] valid_ff;
   logic [IDX_W-1:0]  addr_ff;
   logic              issue_ff;
   logic              chk_ff;
   logic              chk_vld_ff;
   logic              chk_last_ff;
   logic [IDX_W-1:0]  chk_idx_ff;
   logic              rsp_strobe_ff;
   logic [SYM_W-1:0]  rsp_symbol_ff;
   logic              rsp_overflow_error_ff;

   logic              accept;
   logic              load_wr;
   logic [MASK_W-1:0] len_mask;
   entry_type         wr_entry;
   entry_type         rd_entry;
   logic              rd_en;
   logic              hit;
   logic              full;
   logic [ACC_W-1:0]  accum_bits_in;
   logic [ALEN_W-1:0] accum_len_in;

   assign accept  = start && !busy;
   assign load_wr = accept && (req_kind == KIND_LOAD) &&
                    (RNG_W'(req_entry_symbol) < RNG_W'(NUM_SYMBOLS));

   // bits at or above the code length are dropped on store
   assign len_mask      = ~({MASK_W{1'b1}} << req_entry_length);
   assign wr_entry.len  = req_entry_length;
   assign wr_entry.code = req_entry_code & len_mask[CODE_W-1:0];

   assign rd_en = (state_ff == ST_SCAN) && issue_ff;

   pcbd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_SYMBOLS)
   ) u_table (
      .clock   (clock),
      .wr_en   (load_wr),
      .wr_addr (IDX_W'(req_entry_symbol)),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_entry)
   );

   assign hit = chk_ff && chk_vld_ff && (rd_entry.len != '0) &&
                (CLEN_W'(rd_entry.len) == CLEN_W'(accum_len_ff)) &&
                (CMP_W'(rd_entry.code) == CMP_W'(accum_bits_ff));
   assign full = (CLEN_W'(accum_len_ff) >= CLEN_W'(MAX_CODE_LEN));

   assign accum_bits_in = ACC_W'({accum_bits_ff, req_code_bit});
   assign accum_len_in  = full ? accum_len_ff : accum_len_ff + ALEN_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff              <= ST_IDLE;
         accum_bits_ff         <= '0;
         accum_len_ff          <= '0;
         valid_ff              <= '0;
         addr_ff               <= '0;
         issue_ff              <= 1'b0;
         chk_ff                <= 1'b0;
         rsp_strobe_ff         <= 1'b0;
         rsp_overflow_error_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         if (load_wr) begin
            valid_ff[IDX_W'(req_entry_symbol)] <= 1'b1;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept && (req_kind == KIND_BIT)) begin
                  accum_bits_ff <= accum_bits_in;
                  accum_len_ff  <= accum_len_in;
                  addr_ff       <= '0;
                  issue_ff      <= 1'b1;
                  chk_ff        <= 1'b0;
                  state_ff      <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               chk_ff      <= issue_ff;
               chk_idx_ff  <= addr_ff;
               chk_vld_ff  <= valid_ff[addr_ff];
               chk_last_ff <= (addr_ff == IDX_W'(NUM_SYMBOLS - 1));
               if (issue_ff) begin
                  if (addr_ff == IDX_W'(NUM_SYMBOLS - 1)) begin
                     issue_ff <= 1'b0;
                  end else begin
                     addr_ff <= addr_ff + IDX_W'(1);
                  end
               end
               if (hit) begin
                  rsp_strobe_ff         <= 1'b1;
                  rsp_symbol_ff         <= SYM_W'(chk_idx_ff);
                  rsp_overflow_error_ff <= 1'b0;
                  accum_bits_ff         <= '0;
                  accum_len_ff          <= '0;
                  issue_ff              <= 1'b0;
                  chk_ff                <= 1'b0;
                  state_ff              <= ST_IDLE;
               end else if (chk_ff && chk_last_ff) begin
                  // table exhausted; a full accumulator is an error
                  if (full) begin
                     rsp_strobe_ff         <= 1'b1;
                     rsp_symbol_ff         <= '0;
                     rsp_overflow_error_ff <= 1'b1;
                     accum_bits_ff         <= '0;
                     accum_len_ff          <= '0;
                  end
                  chk_ff   <= 1'b0;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_symbol         = rsp_symbol_ff;
   assign rsp_overflow_error = rsp_overflow_error_ff;

`ifndef SYNTHESIS
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("back-to-back result strobes");

   a_error_symbol: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_overflow_error |-> rsp_symbol == '0)
      else $error("overflow result with nonzero symbol");

   a_bit_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_kind == KIND_BIT) |=> busy)
      else $error("bit transaction did not start a scan");

   a_accum_cleared: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (accum_len_ff == '0) && !busy)
      else $error("accumulator not cleared with result");

   a_accum_bound: assert property (@(posedge clock) disable iff (reset)
      CLEN_W'(accum_len_ff) <= CLEN_W'(MAX_CODE_LEN))
      else $error("accumulated length beyond maximum");
`endif

endmodule
